FILE: src/vns_pkg.sv
// Package for the vertex normal smoothing core: command codes, result kinds,
// register indexes and shared types. Used by all modules under src.
`timescale 1ns / 1ps
`default_nettype none
package vns_pkg;
   localparam logic [1:0] FUNC_LOAD   = 2'd0;
   localparam logic [1:0] FUNC_SMOOTH = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic KIND_DONE = 1'b0;
   localparam logic KIND_READ = 1'b1;
   localparam logic [1:0] REG_STRICT = 2'd0;
   localparam logic [1:0] REG_PASSES = 2'd1;
   localparam logic [1:0] REG_LIMIT  = 2'd2;
   localparam logic [32:0] AXIS_LIMIT = 33'd1364;
   localparam logic [32:0] AXIS_MAX   = 33'd8192;
   localparam logic [66:0] POS_RADIUS_SQ = 67'd67108864;
   localparam logic [14:0] UNIT_NORM = 15'd16384;

   typedef struct packed {
      logic        strict_mode;
      logic [3:0]  pass_count;
      logic [14:0] limit;
   } cfg_type;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } norm_type;
endpackage
`default_nettype wire

FILE: src/vns_norm.sv
// Normalizing unit for the smoothing core: scales a summed normal to unit
// length by a binary search of each component. Depends on vns_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vns_norm #(
   parameter int SUM_W = 27
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  wire [SUM_W-1:0]  sum_x,
   input  wire [SUM_W-1:0]  sum_y,
   input  wire [SUM_W-1:0]  sum_z,
   output logic             done,
   output vns_pkg::norm_type result
);
   localparam logic [2:0] S_IDLE = 3'd0, S_SHIFT = 3'd1, S_SQ = 3'd2,
      S_MID = 3'd3, S_O2 = 3'd4, S_CMP = 3'd5, S_NEXT = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [SUM_W-1:0] mag_ff [3];
   logic [SUM_W-1:0] mag_in [3];
   logic [2:0]       sgn_ff, sgn_in;
   logic [1:0]       axis_ff, axis_in;
   logic [33:0]      len2_ff, len2_in;
   logic [14:0]      lo_ff, lo_in, hi_ff, hi_in;
   logic [14:0]      mid;
   logic [29:0]      o2_ff, o2_in;
   logic [62:0]      t_ff, t_in;
   logic [15:0]      q_ff [3];
   logic [15:0]      q_in [3];
   logic [63:0]      prod;
   logic [15:0]      a_cur;
   logic [15:0]      mx16;

   assign mid   = 15'((16'(lo_ff) + 16'(hi_ff) + 16'd1) >> 1);
   assign a_cur = mag_ff[axis_ff][15:0];
   assign prod  = 64'(o2_ff) * 64'(len2_ff);
   assign mx16  = 16'((mag_ff[0] | mag_ff[1] | mag_ff[2]) >> 16);

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      sgn_in   = sgn_ff;
      axis_in  = axis_ff;
      len2_in  = len2_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      o2_in    = o2_ff;
      t_in     = t_ff;
      q_in     = q_ff;
      done     = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               sgn_in = {sum_z[SUM_W-1], sum_y[SUM_W-1], sum_x[SUM_W-1]};
               mag_in[0] = sum_x[SUM_W-1] ? -sum_x : sum_x;
               mag_in[1] = sum_y[SUM_W-1] ? -sum_y : sum_y;
               mag_in[2] = sum_z[SUM_W-1] ? -sum_z : sum_z;
               len2_in = '0;
               axis_in = '0;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (mx16 != 16'd0) begin
               mag_in[0] = mag_ff[0] >> 1;
               mag_in[1] = mag_ff[1] >> 1;
               mag_in[2] = mag_ff[2] >> 1;
            end else begin
               state_in = S_SQ;
            end
         end
         S_SQ: begin
            len2_in = len2_ff + 34'(32'(a_cur) * 32'(a_cur));
            if (axis_ff == 2'd2) begin
               axis_in = '0;
               lo_in = '0;
               hi_in = vns_pkg::UNIT_NORM;
               t_in = 63'(32'(mag_ff[0][15:0]) * 32'(mag_ff[0][15:0])) << 30;
               state_in = S_MID;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         S_MID: begin
            if (t_ff == '0 && axis_ff == 2'd0 && len2_ff == '0) begin
               q_in[axis_ff] = '0;
               state_in = S_NEXT;
            end else if (lo_ff < hi_ff) begin
               o2_in = 30'(15'(2 * 16'(mid) - 16'd1)) * 30'(15'(2 * 16'(mid) - 16'd1));
               state_in = S_O2;
            end else begin
               q_in[axis_ff] = sgn_ff[axis_ff] ? -16'(lo_ff) : 16'(lo_ff);
               state_in = S_NEXT;
            end
         end
         S_O2: state_in = S_CMP;
         S_CMP: begin
            if (prod <= 64'(t_ff)) lo_in = mid;
            else hi_in = mid - 15'd1;
            state_in = S_MID;
         end
         S_NEXT: begin
            if (len2_ff == '0) q_in[axis_ff] = '0;
            if (axis_ff == 2'd2) begin
               done = 1'b1;
               state_in = S_IDLE;
            end else begin
               axis_in = axis_ff + 2'd1;
               lo_in = '0;
               hi_in = vns_pkg::UNIT_NORM;
               t_in = 63'(32'(mag_ff[axis_ff + 2'd1][15:0]) *
                      32'(mag_ff[axis_ff + 2'd1][15:0])) << 30;
               state_in = S_MID;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      sgn_ff  <= sgn_in;
      axis_ff <= axis_in;
      len2_ff <= len2_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      o2_ff   <= o2_in;
      t_ff    <= t_in;
      q_ff    <= q_in;
   end

   assign result.x = q_in[0];
   assign result.y = q_in[1];
   assign result.z = q_in[2];
endmodule
`default_nettype wire

FILE: src/vertex_normal_smoothing_core.sv
// Vertex normal smoothing core. A smooth beat runs pass_count passes; each
// vertex reads all N vertices from the vertex memory, one pair through the
// S_RDJ, S_CMP, S_ACC and S_WAIT states, then goes through the normalizing
// unit. A read result is registered through S_RD1 and S_RD2 before it is
// valid, and no new beat is taken while a result waits. Depends on vns_pkg
// and vns_norm.
`timescale 1ns / 1ps
`default_nettype none
module vertex_normal_smoothing_core #(
   parameter int MAX_VERTS = 1024
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // func[1:0], first_vertex[2], pos_x[34:3], pos_y[66:35], pos_z[98:67],
   // in_norm_x[114:99], in_norm_y[130:115], in_norm_z[146:131], read_index[156:147]
   input  wire [159:0] req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic        rsp_tuser,   // kind
   // index_ok[0], out_norm_x[16:1], out_norm_y[32:17], out_norm_z[48:33]
   output logic [55:0] rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire [3:0]   csr_paddr,
   input  wire [31:0]  csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int AW = $clog2(MAX_VERTS);
   localparam int CW = $clog2(MAX_VERTS + 1);
   localparam int SW = CW + 17;
   localparam logic [3:0] S_IDLE = 4'd0, S_RDI = 4'd1, S_GETI = 4'd2,
      S_RDJ = 4'd3, S_CMP = 4'd4, S_ACC = 4'd5, S_NORM = 4'd6, S_WAIT = 4'd7,
      S_OUT = 4'd8, S_RD1 = 4'd9, S_RD2 = 4'd10, S_QP = 4'd11, S_QS = 4'd12;

   logic [95:0] pos_mem [MAX_VERTS];
   logic [47:0] nrm_mem [MAX_VERTS];
   logic [95:0] pos_q;
   logic [47:0] nrm_q;
   logic [AW-1:0] raddr;
   logic        we;
   logic [AW-1:0] waddr;
   logic [47:0] wnrm;

   vns_pkg::cfg_type cfg_ff;
   logic [3:0]  state_ff;
   logic [CW-1:0] count_ff;
   logic [3:0]  pass_ff;
   logic [CW-1:0] i_ff, j_ff;
   logic [95:0] pi_ff;
   logic [47:0] ni_ff;
   logic [95:0] pj_ff;
   logic [47:0] nj_ff;
   logic [SW-1:0] sx_ff, sy_ff, sz_ff;
   logic        out_kind_ff, out_ok_ff, rsp_valid_ff;
   logic [47:0] out_n_ff;
   logic        nstart;
   logic        ndone;
   vns_pkg::norm_type nres;
   logic [32:0] dx, dy, dz, ax, ay, az;
   logic [16:0] nx, ny, nz;
   logic [36:0] nd_ff;
   logic [66:0] pd_ff;
   logic        near_axis_ff, far_ff, same_ff;
   logic        qual;
   logic [1:0]  func;
   logic [AW-1:0] rindex;
   logic        ld_ok;

   assign func   = req_tdata[1:0];
   assign rindex = AW'(req_tdata[156:147]);
   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_pready = 1'b1;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[3:2])
         vns_pkg::REG_STRICT: csr_prdata = 32'(cfg_ff.strict_mode);
         vns_pkg::REG_PASSES: csr_prdata = 32'(cfg_ff.pass_count);
         vns_pkg::REG_LIMIT:  csr_prdata = 32'(cfg_ff.limit);
         default:             csr_prdata = '0;
      endcase
   end

   assign dx = 33'(signed'(pi_ff[31:0])) - 33'(signed'(pj_ff[31:0]));
   assign dy = 33'(signed'(pi_ff[63:32])) - 33'(signed'(pj_ff[63:32]));
   assign dz = 33'(signed'(pi_ff[95:64])) - 33'(signed'(pj_ff[95:64]));
   assign ax = dx[32] ? -dx : dx;
   assign ay = dy[32] ? -dy : dy;
   assign az = dz[32] ? -dz : dz;
   assign nx = 17'(signed'(ni_ff[15:0])) - 17'(signed'(nj_ff[15:0]));
   assign ny = 17'(signed'(ni_ff[31:16])) - 17'(signed'(nj_ff[31:16]));
   assign nz = 17'(signed'(ni_ff[47:32])) - 17'(signed'(nj_ff[47:32]));

   always_comb begin
      if (cfg_ff.strict_mode)
         qual = same_ff && (nd_ff < 37'(30'(cfg_ff.limit) * 30'(cfg_ff.limit)));
      else
         qual = !far_ff && (pd_ff <= vns_pkg::POS_RADIUS_SQ) &&
                ((nd_ff < 37'(30'(cfg_ff.limit) * 30'(cfg_ff.limit))) || near_axis_ff);
   end

   assign ld_ok = req_tdata[2] || (count_ff != CW'(MAX_VERTS));

   always_comb begin
      we = 1'b0;
      waddr = AW'(i_ff);
      wnrm = {nres.z, nres.y, nres.x};
      raddr = AW'(j_ff);
      if (state_ff == S_IDLE && req_tvalid && req_tready && func == vns_pkg::FUNC_LOAD
          && ld_ok) begin
         we = 1'b1;
         waddr = req_tdata[2] ? '0 : AW'(count_ff);
         wnrm = req_tdata[146:99];
      end else if (ndone) begin
         we = 1'b1;
      end
      if (state_ff == S_IDLE) raddr = rindex;
      else if (state_ff == S_RDI) raddr = AW'(i_ff);
   end

   always_ff @(posedge clock) begin
      if (we) begin
         nrm_mem[waddr] <= wnrm;
         if (state_ff == S_IDLE) pos_mem[waddr] <= req_tdata[98:3];
      end
      pos_q <= pos_mem[raddr];
      nrm_q <= nrm_mem[raddr];
   end

   vns_norm #(.SUM_W(SW)) u_norm (
      .clock(clock), .reset(reset), .start(nstart),
      .sum_x(sx_ff), .sum_y(sy_ff), .sum_z(sz_ff),
      .done(ndone), .result(nres)
   );
   assign nstart = (state_ff == S_NORM);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff <= '{strict_mode: 1'b0, pass_count: 4'd3, limit: 15'd16384};
      end else begin
         if (csr_psel && csr_penable && csr_pwrite) begin
            unique case (csr_paddr[3:2])
               vns_pkg::REG_STRICT: cfg_ff.strict_mode <= csr_pwdata[0];
               vns_pkg::REG_PASSES: cfg_ff.pass_count <= csr_pwdata[3:0];
               vns_pkg::REG_LIMIT:  cfg_ff.limit <= csr_pwdata[14:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  unique case (func)
                     vns_pkg::FUNC_LOAD: begin
                        if (ld_ok)
                           count_ff <= req_tdata[2] ? CW'(1) : count_ff + CW'(1);
                        else if (req_tdata[2])
                           count_ff <= '0;
                     end
                     vns_pkg::FUNC_SMOOTH: begin
                        pass_ff <= '0;
                        i_ff <= '0;
                        state_ff <= S_QP;
                     end
                     vns_pkg::FUNC_READ: begin
                        out_ok_ff <= 32'(req_tdata[156:147]) < 32'(count_ff) &&
                                     32'(req_tdata[156:147]) < 32'(MAX_VERTS);
                        state_ff <= S_RD1;
                     end
                     default: ;
                  endcase
               end
            end
            S_RD1: begin
               out_n_ff <= out_ok_ff ? nrm_q : '0;
               state_ff <= S_RD2;
            end
            S_RD2: begin
               out_kind_ff <= vns_pkg::KIND_READ;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            S_QP: begin
               i_ff <= '0;
               if (pass_ff == cfg_ff.pass_count || count_ff == '0) state_ff <= S_OUT;
               else state_ff <= S_RDI;
            end
            S_QS: begin
               if (i_ff == count_ff) begin
                  pass_ff <= pass_ff + 4'd1;
                  state_ff <= S_QP;
               end else begin
                  state_ff <= S_RDI;
               end
            end
            S_RDI: state_ff <= S_GETI;
            S_GETI: begin
               pi_ff <= pos_q;
               ni_ff <= nrm_q;
               sx_ff <= SW'(signed'(nrm_q[15:0]));
               sy_ff <= SW'(signed'(nrm_q[31:16]));
               sz_ff <= SW'(signed'(nrm_q[47:32]));
               j_ff <= '0;
               state_ff <= S_RDJ;
            end
            S_RDJ: begin
               if (j_ff == count_ff) state_ff <= S_NORM;
               else state_ff <= S_CMP;
            end
            S_CMP: begin
               pj_ff <= pos_q;
               nj_ff <= nrm_q;
               state_ff <= S_ACC;
            end
            S_ACC: begin
               same_ff <= (dx == '0) && (dy == '0) && (dz == '0);
               far_ff <= ax > vns_pkg::AXIS_MAX || ay > vns_pkg::AXIS_MAX ||
                         az > vns_pkg::AXIS_MAX;
               near_axis_ff <= ax < vns_pkg::AXIS_LIMIT && ay < vns_pkg::AXIS_LIMIT &&
                               az < vns_pkg::AXIS_LIMIT;
               pd_ff <= 67'(28'(ax) * 28'(ax)) + 67'(28'(ay) * 28'(ay)) +
                        67'(28'(az) * 28'(az));
               nd_ff <= 37'(34'(signed'(nx)) * 34'(signed'(nx))) +
                        37'(34'(signed'(ny)) * 34'(signed'(ny))) +
                        37'(34'(signed'(nz)) * 34'(signed'(nz)));
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               if (qual && j_ff != i_ff) begin
                  sx_ff <= sx_ff + SW'(signed'(nj_ff[15:0]));
                  sy_ff <= sy_ff + SW'(signed'(nj_ff[31:16]));
                  sz_ff <= sz_ff + SW'(signed'(nj_ff[47:32]));
               end
               j_ff <= j_ff + CW'(1);
               state_ff <= S_RDJ;
            end
            S_NORM: state_ff <= S_OUT;
            S_OUT: begin
               if (ndone) begin
                  i_ff <= i_ff + CW'(1);
                  state_ff <= S_QS;
               end else if (pass_ff == cfg_ff.pass_count || count_ff == '0) begin
                  out_kind_ff <= vns_pkg::KIND_DONE;
                  out_ok_ff <= 1'b0;
                  out_n_ff <= '0;
                  rsp_valid_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {7'd0, out_n_ff, out_ok_ff};
endmodule
`default_nettype wire
